@@ hdl/rcw_pkg.sv @@
// ----------------------------------------------------------------------------
// rcw_pkg
// Shared types and constants for the Reno congestion window block.
// ----------------------------------------------------------------------------
package rcw_pkg;

    localparam int RCW_SEQ_BITS     = 32;
    localparam int WIN_BITS         = 32;
    localparam int SEG_BITS         = 16;
    localparam int SEQ_PORT_BITS    = 32;
    localparam int CFG_DATA_BITS    = 32;
    localparam int S_TDATA_BITS     = 40;
    localparam int M_TDATA_BITS     = 72;
    localparam int DIV_CNT_BITS     = $clog2(WIN_BITS);

    localparam logic [SEG_BITS-1:0] SEG_RESET = 16'd1460;
    localparam logic [WIN_BITS-1:0] WIN_RESET = 32'd14600;

    // configuration register indexes
    localparam logic REG_SEGMENT_SIZE   = 1'b0;
    localparam logic REG_INITIAL_WINDOW = 1'b1;

    // item kinds carried on tuser
    localparam logic CMD_ACK  = 1'b0;
    localparam logic CMD_SENT = 1'b1;

    typedef struct packed {
        logic load;       // latch the accepted item
        logic div_start;  // start the window / segment divide
        logic commit;     // update state and load the output register
    } rcw_cmd_t;

    typedef struct packed {
        logic need_div;   // incoming item is an unmarked ack in congestion avoidance
        logic div_done;
        logic out_free;   // output register empty or being taken
    } rcw_status_t;

endpackage

@@ hdl/rcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// rcw_ctrl
// Sequencer: accepts one item, runs the divide when needed, commits the result.
// ----------------------------------------------------------------------------
module rcw_ctrl
    import rcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  rcw_status_t status,
    output rcw_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV    = 3'b010,
        ST_COMMIT = 3'b100
    } rcw_state_t;

    rcw_state_t state_reg;
    rcw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    cmd.div_start = status.need_div;
                    state_next    = status.need_div ? ST_DIV : ST_COMMIT;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/rcw_datapath.sv @@
// ----------------------------------------------------------------------------
// rcw_datapath
// Window state, bit-serial window divider, update logic and output register.
// ----------------------------------------------------------------------------
module rcw_datapath
    import rcw_pkg::*;
#(
    parameter int SEQ_BITS = RCW_SEQ_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic [S_TDATA_BITS-1:0]  in_data,
    input  logic                     in_kind,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [M_TDATA_BITS-1:0]  out_data,
    input  rcw_cmd_t                 cmd,
    output rcw_status_t              status
);

    localparam int SEQ_IN_BITS = (SEQ_BITS < SEQ_PORT_BITS) ? SEQ_BITS : SEQ_PORT_BITS;
    localparam logic [WIN_BITS-1:0] WORD_MAX = '1;

    // configuration and window state
    logic [SEG_BITS-1:0]     seg_reg,      seg_next;
    logic [WIN_BITS-1:0]     win_reg,      win_next;
    logic [WIN_BITS-1:0]     thr_reg,      thr_next;
    logic                    cwr_reg,      cwr_next;
    logic [WIN_BITS-1:0]     avoid_reg,    avoid_next;
    logic [SEQ_BITS-1:0]     acked_reg,    acked_next;
    logic [SEQ_BITS-1:0]     sent_reg,     sent_next;
    logic [SEQ_BITS-1:0]     recover_reg,  recover_next;

    // latched item
    logic                    item_cmd_reg;
    logic                    item_mark_reg;
    logic [SEQ_BITS-1:0]     item_seq_reg;

    // divider
    logic [WIN_BITS-1:0]     quo_reg,      quo_next;
    logic [SEG_BITS-1:0]     rem_reg,      rem_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg,      cnt_next;
    logic                    busy_reg,     busy_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [WIN_BITS-1:0]     out_cwnd_reg;
    logic [WIN_BITS-1:0]     out_thr_reg;
    logic                    out_cwr_reg;

    logic [SEQ_BITS-1:0]     seq_in;
    logic [SEG_BITS:0]       rem_shift;
    logic [SEG_BITS:0]       rem_diff;
    logic [SEQ_BITS-1:0]     acked_upd;
    logic [SEQ_BITS-1:0]     sent_upd;
    logic [WIN_BITS-1:0]     seg_wide;
    logic [WIN_BITS-1:0]     half_win;
    logic [WIN_BITS-1:0]     halved;
    logic [WIN_BITS:0]       grow_sum;
    logic [WIN_BITS-1:0]     grow_sat;
    logic [WIN_BITS-1:0]     slow_win;
    logic [WIN_BITS-1:0]     win_segs;
    logic [WIN_BITS-1:0]     avoid_inc;
    logic                    in_avoid;

    assign seq_in   = SEQ_BITS'(in_data[SEQ_IN_BITS-1:0]);

    assign in_avoid = (win_reg >= thr_reg);

    assign status.need_div = (in_kind == CMD_ACK) && !in_data[SEQ_PORT_BITS] && in_avoid;
    assign status.div_done = !busy_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    // restoring divide step: one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[WIN_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, seg_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cmd.div_start)
        begin
            quo_next  = win_reg;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!rem_diff[SEG_BITS])
            begin
                rem_next = rem_diff[SEG_BITS-1:0];
                quo_next = {quo_reg[WIN_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[SEG_BITS-1:0];
                quo_next = {quo_reg[WIN_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(WIN_BITS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // update terms
    assign acked_upd = (item_seq_reg > acked_reg) ? item_seq_reg : acked_reg;
    assign sent_upd  = (item_seq_reg > sent_reg)  ? item_seq_reg : sent_reg;
    assign seg_wide  = WIN_BITS'(seg_reg);
    assign half_win  = win_reg >> 1;
    assign halved    = (half_win > seg_wide) ? half_win : seg_wide;
    assign grow_sum  = {1'b0, win_reg} + {1'b0, seg_wide};
    assign grow_sat  = grow_sum[WIN_BITS] ? WORD_MAX : grow_sum[WIN_BITS-1:0];
    assign slow_win  = (grow_sat < thr_reg) ? grow_sat : thr_reg;
    assign win_segs  = ((seg_reg == '0) || (quo_reg == '0)) ? WIN_BITS'(1) : quo_reg;
    assign avoid_inc = (avoid_reg == WORD_MAX) ? avoid_reg : avoid_reg + 1'b1;

    always_comb
    begin
        seg_next     = seg_reg;
        win_next     = win_reg;
        thr_next     = thr_reg;
        cwr_next     = cwr_reg;
        avoid_next   = avoid_reg;
        acked_next   = acked_reg;
        sent_next    = sent_reg;
        recover_next = recover_reg;
        if (cmd.commit)
        begin
            if (item_cmd_reg == CMD_SENT)
            begin
                sent_next = sent_upd;
            end
            else
            begin
                acked_next = acked_upd;
                if (!item_mark_reg)
                begin
                    cwr_next = 1'b0;
                    if (!in_avoid)
                    begin
                        win_next = slow_win;
                    end
                    else if (avoid_reg >= win_segs)
                    begin
                        avoid_next = WIN_BITS'(1);
                        win_next   = grow_sat;
                    end
                    else
                    begin
                        avoid_next = avoid_inc;
                    end
                end
                else if (!cwr_reg)
                begin
                    thr_next     = halved;
                    win_next     = halved;
                    recover_next = sent_reg;
                    cwr_next     = 1'b1;
                end
                else if (acked_upd >= recover_reg)
                begin
                    win_next     = halved;
                    cwr_next     = 1'b0;
                    recover_next = sent_reg;
                end
            end
        end
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_SEGMENT_SIZE:   seg_next = cfg_data[SEG_BITS-1:0];
                REG_INITIAL_WINDOW: win_next = cfg_data[WIN_BITS-1:0];
                default:            seg_next = seg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= SEG_RESET;
            win_reg       <= WIN_RESET;
            thr_reg       <= WORD_MAX;
            cwr_reg       <= 1'b0;
            avoid_reg     <= '0;
            acked_reg     <= '0;
            sent_reg      <= '0;
            recover_reg   <= '0;
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_reg       <= seg_next;
            win_reg       <= win_next;
            thr_reg       <= thr_next;
            cwr_reg       <= cwr_next;
            avoid_reg     <= avoid_next;
            acked_reg     <= acked_next;
            sent_reg      <= sent_next;
            recover_reg   <= recover_next;
            cnt_reg       <= cnt_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            item_cmd_reg  <= in_kind;
            item_mark_reg <= in_data[SEQ_PORT_BITS];
            item_seq_reg  <= seq_in;
        end
        if (cmd.commit)
        begin
            out_cwnd_reg <= win_next;
            out_thr_reg  <= thr_next;
            out_cwr_reg  <= cwr_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {(M_TDATA_BITS - 2 * WIN_BITS - 1)'(0), out_cwr_reg,
                        out_thr_reg, out_cwnd_reg};

endmodule

@@ hdl/reno_congestion_window.sv @@
// ----------------------------------------------------------------------------
// reno_congestion_window
// Reno-style congestion window in bytes, driven by send and ack transfers.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A send event, a marked ack, or an
// unmarked ack in slow start goes from the input transfer to the commit
// state, which loads its result into the output register once that register
// is free; the next input can be taken in the idle state that follows the
// commit. An unmarked ack in congestion avoidance passes through the divide
// state first: the window in segments comes from a bit-serial divide of the
// 32-bit window by the segment size, one quotient bit per cycle, after which
// the divide state sees the divide finish and the commit state commits. The
// next input is taken as soon as the result sits in the output register,
// even while it waits there; that item then holds before its commit until
// the output register is free.
// Configuration writes take effect at once; writing the initial window also
// loads the current window. No clearing pass follows reset.
module reno_congestion_window
    import rcw_pkg::*;
#(
    parameter int SEQ_BITS = RCW_SEQ_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [S_TDATA_BITS-1:0]  s_axis_tdata,   // seq[31:0], congestion[32], zero pad
    input  logic [0:0]               s_axis_tuser,   // cmd[0]
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [M_TDATA_BITS-1:0]  m_axis_tdata    // cwnd[31:0], ssthresh[63:32], in_cwr[64], zero pad
);

    rcw_cmd_t    cmd;
    rcw_status_t status;

    rcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rcw_datapath #(
        .SEQ_BITS (SEQ_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_kind   (s_axis_tuser[0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ hdl/rcw_checker.sv @@
// ----------------------------------------------------------------------------
// rcw_checker
// Port-level checks for the Reno congestion window block, bound to the top.
// ----------------------------------------------------------------------------
module rcw_checker
    import rcw_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [M_TDATA_BITS-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // one item at a time: no input transfer right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    // a new result only follows a cycle with the input side closed
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without an item in progress");

endmodule

bind reno_congestion_window rcw_checker u_rcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
